@@ sv/tpi_pkg.sv @@
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared constants and types of the three-plane intersection core.
// ----------------------------------------------------------------------------
package tpi_pkg;

   // Width of one output coordinate.
   localparam int OUT_W = 32;

   // Quotient bits that the divider forms, one above the output range.
   localparam int QB = OUT_W + 1;

   // Saturation values of a coordinate.
   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // Status codes of a result.
   typedef logic [1:0] status_type;
   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_SINGULAR  = 2'd1;
   localparam status_type STAT_SATURATED = 2'd2;

   // One coordinate as it leaves a divider lane.
   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             sat;
      logic             zero;
   } coord_type;

endpackage

@@ sv/tpi_req_if.sv @@
// ----------------------------------------------------------------------------
// tpi_req_if
// Request channel: three planes with signed fixed-point coefficients.
// ----------------------------------------------------------------------------
interface tpi_req_if #(parameter int COEF_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] p1_a;
   logic signed [COEF_WIDTH-1:0] p1_b;
   logic signed [COEF_WIDTH-1:0] p1_c;
   logic signed [COEF_WIDTH-1:0] p1_d;
   logic signed [COEF_WIDTH-1:0] p2_a;
   logic signed [COEF_WIDTH-1:0] p2_b;
   logic signed [COEF_WIDTH-1:0] p2_c;
   logic signed [COEF_WIDTH-1:0] p2_d;
   logic signed [COEF_WIDTH-1:0] p3_a;
   logic signed [COEF_WIDTH-1:0] p3_b;
   logic signed [COEF_WIDTH-1:0] p3_c;
   logic signed [COEF_WIDTH-1:0] p3_d;

   modport source (output valid, p1_a, p1_b, p1_c, p1_d, p2_a, p2_b, p2_c, p2_d,
                   p3_a, p3_b, p3_c, p3_d, input ready);
   modport sink (input valid, p1_a, p1_b, p1_c, p1_d, p2_a, p2_b, p2_c, p2_d,
                 p3_a, p3_b, p3_c, p3_d, output ready);
endinterface

@@ sv/tpi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tpi_rsp_if
// Response channel: intersection point and status.
// ----------------------------------------------------------------------------
interface tpi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [1:0]         status;

   modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

@@ sv/tpi_det3.sv @@
// ----------------------------------------------------------------------------
// tpi_det3
// Five-stage pipelined exact 3x3 determinant of a row-major matrix.
// ----------------------------------------------------------------------------
module tpi_det3 #(
   parameter int W = 32,
   localparam int PW = 2 * W,
   localparam int CW1 = 2 * W + 1,
   localparam int TW = 3 * W + 1,
   localparam int DW = 3 * W + 3
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [W-1:0]  m_i [9],
   output logic signed [DW-1:0] det_o
);

   logic signed [PW-1:0]  prod_in [6];
   logic signed [PW-1:0]  prod_ff [6];
   logic signed [W-1:0]   row1_ff [3];
   logic signed [W-1:0]   row2_ff [3];
   logic signed [CW1-1:0] cof_in [3];
   logic signed [CW1-1:0] cof_ff [3];
   logic signed [CW1-1:0] plo_in [3];
   logic signed [CW1-1:0] plo_ff [3];
   logic signed [CW1-1:0] phi_in [3];
   logic signed [CW1-1:0] phi_ff [3];
   logic signed [TW-1:0]  term_in [3];
   logic signed [TW-1:0]  term_ff [3];
   logic signed [DW-1:0]  det_in;
   logic signed [DW-1:0]  det_ff;

   // Stage one: the six 2x2 minor products of the lower rows.
   always_comb begin
      prod_in[0] = m_i[4] * m_i[8];
      prod_in[1] = m_i[5] * m_i[7];
      prod_in[2] = m_i[3] * m_i[8];
      prod_in[3] = m_i[5] * m_i[6];
      prod_in[4] = m_i[3] * m_i[7];
      prod_in[5] = m_i[4] * m_i[6];
   end

   // Stages two to five: cofactors, split products, terms and the sum.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cof_in[j] = CW1'(prod_ff[2*j]) - CW1'(prod_ff[2*j+1]);
         plo_in[j] = row2_ff[j] * $signed({1'b0, cof_ff[j][W-1:0]});
         phi_in[j] = row2_ff[j] * $signed(cof_ff[j][CW1-1:W]);
         term_in[j] = (TW'(phi_ff[j]) <<< W) + TW'(plo_ff[j]);
      end
      det_in = DW'(term_ff[0]) - DW'(term_ff[1]) + DW'(term_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         row1_ff <= m_i[0:2];
         row2_ff <= row1_ff;
         cof_ff  <= cof_in;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         term_ff <= term_in;
         det_ff  <= det_in;
      end
   end

   assign det_o = det_ff;

endmodule

@@ sv/tpi_div.sv @@
// ----------------------------------------------------------------------------
// tpi_div
// Pipelined restoring divider lane: -num * 2^FRAC / den, rounded half away
// from zero and saturated to the output range.
// ----------------------------------------------------------------------------
module tpi_div import tpi_pkg::*; #(
   parameter int W = 32,
   parameter int FRAC = 16,
   localparam int DW = 3 * W + 3,
   localparam int CW = DW + QB + 1
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] num_i,
   input  logic signed [DW-1:0] den_i,
   output coord_type            coord_o
);

   localparam logic [QB:0] POS_LIM = {{(QB-OUT_W+2){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic [QB:0] NEG_LIM = POS_LIM + 1'b1;

   logic [CW-1:0] rem_in [QB+1];
   logic [CW-1:0] rem_ff [QB+1];
   logic [QB-1:0] quo_in [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic [DW-1:0] den_in [QB+1];
   logic [DW-1:0] den_ff [QB+1];
   logic          neg_in [QB+1];
   logic          neg_ff [QB+1];
   logic          ovf_in [QB+1];
   logic          ovf_ff [QB+1];
   logic          zero_in [QB+1];
   logic          zero_ff [QB+1];
   logic [DW-1:0] num_mag;
   logic          rnd;
   logic [QB:0]   quo_rnd;
   logic          sat;
   coord_type     coord_in;
   coord_type     coord_ff;

   // Entry stage: magnitudes and the sign of the quotient.
   always_comb begin
      num_mag = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
      rem_in[0] = CW'(num_mag) << FRAC;
      quo_in[0] = '0;
      den_in[0] = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_in[0] = (!num_i[DW-1] && (num_i != '0)) ^ den_i[DW-1];
      ovf_in[0] = 1'b0;
      zero_in[0] = (den_i == '0);
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 1; k <= QB; k++) begin : g_step
      localparam int B = QB - k;
      logic [CW-1:0] dsh;
      logic          ge;
      always_comb begin
         dsh = CW'(den_ff[k-1]) << B;
         ge = (rem_ff[k-1] >= dsh);
         rem_in[k] = ge ? (rem_ff[k-1] - dsh) : rem_ff[k-1];
         quo_in[k] = quo_ff[k-1] | (QB'(ge) << B);
         den_in[k] = den_ff[k-1];
         neg_in[k] = neg_ff[k-1];
         zero_in[k] = zero_ff[k-1];
      end
      // The first step also flags a quotient beyond the bits formed here.
      if (k == 1) begin : g_ovf
         assign ovf_in[k] = (rem_ff[k-1] >= (CW'(den_ff[k-1]) << QB));
      end else begin : g_pass
         assign ovf_in[k] = ovf_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= den_in;
         neg_ff  <= neg_in;
         ovf_ff  <= ovf_in;
         zero_ff <= zero_in;
      end
   end

   // Final stage: round, saturate and apply the sign.
   always_comb begin
      rnd = ((CW+1)'(rem_ff[QB]) << 1) >= (CW+1)'(den_ff[QB]);
      quo_rnd = (QB+1)'(quo_ff[QB]) + (QB+1)'(rnd);
      sat = ovf_ff[QB] | (neg_ff[QB] ? (quo_rnd > NEG_LIM) : (quo_rnd > POS_LIM));
      coord_in.sat = sat;
      coord_in.zero = zero_ff[QB];
      if (sat) begin
         coord_in.value = neg_ff[QB] ? OUT_MIN : OUT_MAX;
      end else begin
         coord_in.value = neg_ff[QB] ? -quo_rnd[OUT_W-1:0] : quo_rnd[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= coord_in;
      end
   end

   assign coord_o = coord_ff;

endmodule

@@ sv/three_plane_intersection_core.sv @@
// ----------------------------------------------------------------------------
// three_plane_intersection_core
// Common point of three planes by Cramer's rule with exact determinants.
//
//   Channel  Direction  Contents
//   req      in         p1..p3 a, b, c, d coefficients, signed fixed point
//   rsp      out        pos_x, pos_y, pos_z (Q.FRAC_BITS), status
//
// One transaction is taken per cycle while the response is not stalled; each
// result passes through 5 determinant stages and 35 divider stages (entry, 33
// quotient bits, rounding). The quotient-bit stages set the latency.
// Reset clears only the valid bits of the pipeline.
// A stalled response holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module three_plane_intersection_core import tpi_pkg::*; #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   tpi_req_if.sink    req_chan,
   tpi_rsp_if.source  rsp_chan
);

   localparam int DW = 3 * COEF_WIDTH + 3;
   localparam int LAT = 5 + QB + 2;

   logic                          adv;
   logic [LAT-1:0]                valid_in;
   logic [LAT-1:0]                valid_ff;
   logic signed [COEF_WIDTH-1:0]  mat [9];
   logic signed [COEF_WIDTH-1:0]  mat_x [9];
   logic signed [COEF_WIDTH-1:0]  mat_y [9];
   logic signed [COEF_WIDTH-1:0]  mat_z [9];
   logic signed [DW-1:0]          det_m;
   logic signed [DW-1:0]          det_x;
   logic signed [DW-1:0]          det_y;
   logic signed [DW-1:0]          det_z;
   coord_type                     cx;
   coord_type                     cy;
   coord_type                     cz;

   // The pipeline moves whenever the output stage is empty or being taken.
   assign adv = !valid_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign valid_in = {valid_ff[LAT-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // Coefficient matrix and its three column-replaced copies.
   always_comb begin
      mat = '{req_chan.p1_a, req_chan.p1_b, req_chan.p1_c,
              req_chan.p2_a, req_chan.p2_b, req_chan.p2_c,
              req_chan.p3_a, req_chan.p3_b, req_chan.p3_c};
      mat_x = mat;
      mat_y = mat;
      mat_z = mat;
      mat_x[0] = req_chan.p1_d;
      mat_x[3] = req_chan.p2_d;
      mat_x[6] = req_chan.p3_d;
      mat_y[1] = req_chan.p1_d;
      mat_y[4] = req_chan.p2_d;
      mat_y[7] = req_chan.p3_d;
      mat_z[2] = req_chan.p1_d;
      mat_z[5] = req_chan.p2_d;
      mat_z[8] = req_chan.p3_d;
   end

   tpi_det3 #(.W(COEF_WIDTH)) u_det_m (.clock, .en(adv), .m_i(mat), .det_o(det_m));
   tpi_det3 #(.W(COEF_WIDTH)) u_det_x (.clock, .en(adv), .m_i(mat_x), .det_o(det_x));
   tpi_det3 #(.W(COEF_WIDTH)) u_det_y (.clock, .en(adv), .m_i(mat_y), .det_o(det_y));
   tpi_det3 #(.W(COEF_WIDTH)) u_det_z (.clock, .en(adv), .m_i(mat_z), .det_o(det_z));

   tpi_div #(.W(COEF_WIDTH), .FRAC(FRAC_BITS)) u_div_x (
      .clock, .en(adv), .num_i(det_x), .den_i(det_m), .coord_o(cx));
   tpi_div #(.W(COEF_WIDTH), .FRAC(FRAC_BITS)) u_div_y (
      .clock, .en(adv), .num_i(det_y), .den_i(det_m), .coord_o(cy));
   tpi_div #(.W(COEF_WIDTH), .FRAC(FRAC_BITS)) u_div_z (
      .clock, .en(adv), .num_i(det_z), .den_i(det_m), .coord_o(cz));

   // Response: a singular matrix forces the coordinates to zero.
   assign rsp_chan.valid = valid_ff[LAT-1];
   assign rsp_chan.pos_x = cx.zero ? '0 : cx.value;
   assign rsp_chan.pos_y = cx.zero ? '0 : cy.value;
   assign rsp_chan.pos_z = cx.zero ? '0 : cz.value;

   always_comb begin
      priority if (cx.zero) begin
         rsp_chan.status = STAT_SINGULAR;
      end else if (cx.sat || cy.sat || cz.sat) begin
         rsp_chan.status = STAT_SATURATED;
      end else begin
         rsp_chan.status = STAT_OK;
      end
   end

   // A singular result carries a zero point.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == STAT_SINGULAR) |->
         (rsp_chan.pos_x == '0) && (rsp_chan.pos_y == '0) && (rsp_chan.pos_z == '0))
      else $error("singular result with nonzero coordinates");

   // A saturated result has at least one coordinate at a range limit.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == STAT_SATURATED) |->
         (rsp_chan.pos_x == OUT_MAX) || (rsp_chan.pos_x == OUT_MIN) ||
         (rsp_chan.pos_y == OUT_MAX) || (rsp_chan.pos_y == OUT_MIN) ||
         (rsp_chan.pos_z == OUT_MAX) || (rsp_chan.pos_z == OUT_MIN))
      else $error("saturated status without a saturated coordinate");

   // A stall freezes the valid bits of every stage.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved during a stall");

endmodule
